FILE: rtl/wsp_pkg.sv
// Shared types, constants and helpers for the world-to-screen projection core.
`default_nettype none
package wsp_pkg;

    // Widths of the clip arithmetic.
    localparam int CLIP_W = 58;
    localparam int NUM_W  = 59;
    localparam int K_W    = 21;
    localparam int QB_W   = 34;

    localparam int DefQueueDepth = 4;

    localparam logic signed [CLIP_W-1:0] W_MIN_Q24   = CLIP_W'(16778);
    localparam logic signed [CLIP_W-1:0] OFF_LIMIT   = CLIP_W'(64'sd1099511627776);
    localparam logic [16:0]              OFF_SCALE   = 17'd100000;
    localparam logic [13:0]              RST_WIDTH   = 14'd1920;
    localparam logic [13:0]              RST_HEIGHT  = 14'd1080;

    typedef enum logic [2:0] {
        CFG_ROW_X_01 = 3'd0,
        CFG_ROW_X_23 = 3'd1,
        CFG_ROW_Y_01 = 3'd2,
        CFG_ROW_Y_23 = 3'd3,
        CFG_ROW_W_01 = 3'd4,
        CFG_ROW_W_23 = 3'd5,
        CFG_WIDTH    = 3'd6,
        CFG_HEIGHT   = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               on_screen;
    } t_out_word;

    // Classified job handed from the front to the back through the queue.
    typedef struct packed {
        logic                     on_screen;
        logic signed [CLIP_W-1:0] w;
        logic signed [NUM_W-1:0]  num_x;
        logic signed [NUM_W-1:0]  num_y;
        logic [K_W-1:0]           k_x;
        logic [K_W-1:0]           k_y;
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wsp_front.sv
// Front end: matrix-vector product for clip x, y, w and visibility classification.
`default_nettype none
module wsp_front import wsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_in_word    i_word,
    input  wire logic        i_advance,
    input  wire logic [63:0] i_rows [6],
    input  wire logic [13:0] i_width,
    input  wire logic [13:0] i_height,
    output logic             o_valid,
    output t_job             o_job,
    output logic [1:0]       o_pending
);

    // Stage 1: nine 32x24 products, registered.
    logic signed [55:0] r_prod [9];
    logic signed [31:0] r_m3 [3];
    logic               r_v1;
    // Stage 2: clip sums.
    logic signed [CLIP_W-1:0] r_clip [3];
    logic                     r_v2;
    logic [13:0]              r_wd, r_ht;
    // Stage 3: job register.
    t_job r_job;
    logic r_v3;

    logic signed [23:0] pts [3];
    assign pts[0] = i_word.point_x;
    assign pts[1] = i_word.point_y;
    assign pts[2] = i_word.point_z;

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[3*r]   <= $signed(i_rows[2*r][31:0])   * pts[0];
                r_prod[3*r+1] <= $signed(i_rows[2*r][63:32])  * pts[1];
                r_prod[3*r+2] <= $signed(i_rows[2*r+1][31:0]) * pts[2];
                r_m3[r]       <= $signed(i_rows[2*r+1][63:32]);
            end
            for (int r = 0; r < 3; r++) begin
                r_clip[r] <= CLIP_W'(r_prod[3*r]) + CLIP_W'(r_prod[3*r+1])
                           + CLIP_W'(r_prod[3*r+2]) + (CLIP_W'(r_m3[r]) <<< 8);
            end
            r_wd <= i_width;
            r_ht <= i_height;
        end
    end

    t_job n_job;
    always_comb begin
        n_job.w         = r_clip[2];
        n_job.cx        = r_clip[0];
        n_job.cy        = r_clip[1];
        n_job.on_screen = (r_clip[2] >= W_MIN_Q24);
        n_job.num_x     = NUM_W'(r_clip[2]) + NUM_W'(r_clip[0]);
        n_job.num_y     = NUM_W'(r_clip[2]) - NUM_W'(r_clip[1]);
        n_job.k_x       = {r_wd, 7'd0};
        n_job.k_y       = {r_ht, 7'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_advance) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid   = r_v3;
    assign o_job     = r_job;
    assign o_pending = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule
`default_nettype wire

FILE: rtl/wsp_queue.sv
// Small FIFO of classified jobs between front and back.
`default_nettype none
module wsp_queue import wsp_pkg::*; #(
    parameter int Depth = DefQueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job,
    output logic [$clog2(Depth+1)-1:0] o_count
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    t_job r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(Depth+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (32'(r_wp) == Depth - 1) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (32'(r_rp) == Depth - 1) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule
`default_nettype wire

FILE: rtl/wsp_back.sv
// Back end: pipelined restoring divider, pixel mapping, saturation, output stage.
`default_nettype none
module wsp_back import wsp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_job i_job,
    output logic      o_take,
    output logic      o_valid,
    output t_out_word o_word,
    input  wire logic i_stall
);
    // Division floor(n*k/w) split as q = floor(n/w), r = n mod w, then
    // floor(r*k/w). Both quotients come from one bit per stage.
    localparam int QS = QB_W;        // integer quotient bits (saturating)
    localparam int FS = K_W;         // remainder product bits
    localparam int NS = QS + FS + 3;

    typedef struct packed {
        logic                     on;
        logic                     neg;
        logic                     zx, zy;
        logic [CLIP_W-1:0]        w;
        logic [NUM_W-1:0]         ax, ay;   // magnitude of numerator
        logic                     nx, ny;
        logic [QS-1:0]            qx, qy;
        logic [CLIP_W:0]          rx, ry;
        logic [K_W-1:0]           kx, ky;
        logic [K_W-1:0]           fx, fy;
        logic [CLIP_W:0]          ex, ey;
        logic signed [31:0]       ox, oy;
        logic                     ovx, ovy;
    } t_slot;

    t_slot r_s [NS];
    logic  r_v [NS];
    logic  adv;
    logic  r_ov;
    t_out_word r_out;

    assign adv    = !(r_ov && i_stall);
    assign o_take = adv;

    // Offscreen scale: floor(c*100000 / 2^16), saturated.
    function automatic logic signed [31:0] off_scale(input logic signed [CLIP_W-1:0] c);
        logic signed [63:0] p;
        if (c > OFF_LIMIT) return 32'sh7fffffff;
        if (c < -OFF_LIMIT) return 32'sh80000000;
        p = (64'(c) * $signed({1'b0, OFF_SCALE})) >>> 16;
        return sat32(p);
    endfunction

    // One restoring step of n / w on magnitudes.
    function automatic logic [CLIP_W:0] rstep(input logic [CLIP_W:0] r, input logic b,
                                              input logic [CLIP_W-1:0] w, output logic q);
        logic [CLIP_W+1:0] t;
        t = {r, b};
        if (t >= {2'b00, w}) begin
            q = 1'b1;
            return (CLIP_W+1)'(t - {2'b00, w});
        end
        q = 1'b0;
        return t[CLIP_W:0];
    endfunction

    // Fractional step of the remainder multiply-divide loop for floor(r*k/w).
    function automatic void fstep(inout logic [CLIP_W:0] rem, inout logic [K_W-1:0] qq,
                                  input logic [CLIP_W:0] r, input logic kb,
                                  input logic [CLIP_W-1:0] w);
        logic [CLIP_W+1:0] t;
        t = {rem, 1'b0};
        qq = {qq[K_W-2:0], 1'b0};
        if (t >= {2'b00, w}) begin t = t - {2'b00, w}; qq = qq + 1'b1; end
        if (kb) begin
            t = t + {1'b0, r};
            if (t >= {2'b00, w}) begin t = t - {2'b00, w}; qq = qq + 1'b1; end
        end
        rem = t[CLIP_W:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Stage 0: magnitudes, offscreen values.
            r_s[0].on <= i_job.on_screen;
            r_s[0].w  <= i_job.w;
            r_s[0].nx <= i_job.num_x[NUM_W-1];
            r_s[0].ny <= i_job.num_y[NUM_W-1];
            r_s[0].ax <= i_job.num_x[NUM_W-1] ? -i_job.num_x : i_job.num_x;
            r_s[0].ay <= i_job.num_y[NUM_W-1] ? -i_job.num_y : i_job.num_y;
            r_s[0].kx <= i_job.k_x;
            r_s[0].ky <= i_job.k_y;
            r_s[0].zx <= (i_job.k_x == '0);
            r_s[0].zy <= (i_job.k_y == '0);
            r_s[0].neg <= 1'b0;
            r_s[0].qx <= '0; r_s[0].qy <= '0;
            r_s[0].rx <= '0; r_s[0].ry <= '0;
            r_s[0].fx <= '0; r_s[0].fy <= '0;
            r_s[0].ex <= '0; r_s[0].ey <= '0;
            r_s[0].ovx <= 1'b0; r_s[0].ovy <= 1'b0;
            r_s[0].ox <= off_scale(i_job.cx);
            r_s[0].oy <= off_scale(i_job.cy);
            // Stage 1: prepend the numerator bits above the quotient window.
            // The quotient window holds QS bits; higher set quotient bits flag
            // overflow, found by comparing the high part with w.
            begin
                t_slot s;
                logic [NUM_W-1:0] hx, hy;
                s  = r_s[0];
                hx = s.ax >> QS;
                hy = s.ay >> QS;
                s.ovx = ({1'b0, hx} >= {1'b0, NUM_W'(s.w)});
                s.ovy = ({1'b0, hy} >= {1'b0, NUM_W'(s.w)});
                s.rx  = (CLIP_W+1)'(hx);
                s.ry  = (CLIP_W+1)'(hy);
                r_s[1] <= s;
            end
            // Integer quotient stages, one bit each.
            for (int i = 0; i < QS; i++) begin
                t_slot s;
                logic qb;
                s = r_s[1+i];
                s.rx = rstep(s.rx, s.ax[QS-1-i], s.w, qb);
                s.qx = {s.qx[QS-2:0], qb};
                s.ry = rstep(s.ry, s.ay[QS-1-i], s.w, qb);
                s.qy = {s.qy[QS-2:0], qb};
                r_s[2+i] <= s;
            end
            // Floor correction for negative numerators.
            begin
                t_slot s;
                s = r_s[QS+1];
                if (s.nx && s.rx != '0) begin
                    s.qx = s.qx + 1'b1;
                    s.ovx = s.ovx | (s.qx == '0);
                    s.rx = (CLIP_W+1)'({1'b0, s.w}) - s.rx;
                end
                if (s.ny && s.ry != '0) begin
                    s.qy = s.qy + 1'b1;
                    s.ovy = s.ovy | (s.qy == '0);
                    s.ry = (CLIP_W+1)'({1'b0, s.w}) - s.ry;
                end
                r_s[QS+2] <= s;
            end
            // Fractional stages: floor(r*k/w), one bit of k each.
            for (int i = 0; i < FS; i++) begin
                t_slot s;
                s = r_s[QS+2+i];
                fstep(s.ex, s.fx, s.rx, s.kx[FS-1-i], s.w);
                fstep(s.ey, s.fy, s.ry, s.ky[FS-1-i], s.w);
                r_s[QS+3+i] <= s;
            end
        end
    end

    // Final combine: +/- q*k + qq, saturate.
    function automatic logic signed [31:0] combine(input logic neg, input logic ov,
                                                   input logic z, input logic [QS-1:0] q,
                                                   input logic [K_W-1:0] k,
                                                   input logic [K_W-1:0] f);
        logic signed [QS+1:0]  sq;
        logic signed [63:0]    p;
        if (z) return 32'sd0;
        if (ov) return neg ? 32'sh80000000 : 32'sh7fffffff;
        sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        if (sq > (QS+2)'(64'sd2147483648)) return 32'sh7fffffff;
        if (sq < -(QS+2)'(64'sd4294967296)) return 32'sh80000000;
        p = 64'(sq) * $signed({1'b0, k}) + $signed({43'd0, f});
        return sat32(p);
    endfunction

    t_out_word n_out;
    always_comb begin
        t_slot s;
        s = r_s[NS-1];
        n_out.on_screen = s.on;
        if (s.on) begin
            n_out.screen_x = combine(s.nx, s.ovx, s.zx, s.qx, s.kx, s.fx);
            n_out.screen_y = combine(s.ny, s.ovy, s.zy, s.qy, s.ky, s.fy);
        end else begin
            n_out.screen_x = s.ox;
            n_out.screen_y = s.oy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_v[i] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < NS; i++) r_v[i] <= r_v[i-1];
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_word  = r_out;
endmodule
`default_nettype wire

FILE: rtl/world_to_screen_projection_core.sv
// Top level of the world-to-screen projection core.
`default_nettype none
// Projects one world point (signed Q16.8 x, y, z) per word through rows 0, 1
// and 3 of a view-projection matrix held in configuration registers, and
// returns pixel coordinates in signed Q24.8 with an on-screen flag. A point
// whose clip w is below 0.001 is flagged off screen and carries clip x and y
// scaled by 100000. The core accepts one word per cycle while o_stall is low.
// While the output is not held off, the result word passes through the three
// front stages of products and sums, the job queue, the 58 stages of the
// pipelined bit-per-stage divider and the output register. The job queue
// holds QueueDepth + 4 words; the input stalls once the words in that queue
// together with those in the three front stages would fill it, which only
// happens while the receiver holds off the output. The user must write
// configuration only while the core holds no word; it is not enforced.
module world_to_screen_projection_core import wsp_pkg::*; #(
    parameter int QueueDepth = DefQueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_word    i_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_word        o_word,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_cfg_ready
);
    localparam int QD = QueueDepth + 4;

    logic [63:0] r_rows [6];
    logic [13:0] r_width, r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_rows[i] <= '0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[13:0];
                CFG_HEIGHT: r_height <= i_cfg_data[13:0];
                default:    r_rows[i_cfg_index] <= i_cfg_data;
            endcase
        end
    end

    // Every word in the front stages is already promised a queue entry, so a
    // new word is taken only while the queue plus those words leave room.
    logic f_valid, q_valid, b_take;
    t_job f_job, q_job;
    logic [1:0] f_pending;
    logic [$clog2(QD+1)-1:0] q_cnt;

    assign o_stall = (32'(q_cnt) + 32'(f_pending) >= QD);

    wsp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid   (i_valid && !o_stall),
        .i_word    (i_word),
        .i_advance (1'b1),
        .i_rows    (r_rows),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_valid   (f_valid),
        .o_job     (f_job),
        .o_pending (f_pending)
    );

    wsp_queue #(.Depth(QD)) u_queue (
        .i_clk, .i_rst_n,
        .i_push  (f_valid),
        .i_job   (f_job),
        .i_pop   (q_valid && b_take),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_cnt)
    );

    wsp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_take  (b_take),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("result word changed while stalled");
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_cnt) + 32'(f_pending) <= QD)
        else $error("job queue overcommitted");
endmodule
`default_nettype wire
